FILE: hw/rtl/bmhq_pkg.sv
// Package for the bounded max-heap queue: default sizes, result status codes,
// configuration register indexes, their reset values and the operation codes.
// No dependencies; the top level and the checker import it.
package bmhq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int STATUS_W  = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_UPPER = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOWER = 1'd1;

  localparam int UPPER_RESET = 100;
  localparam int LOWER_RESET = 0;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

endpackage

FILE: hw/rtl/bmhq_ram.sv
// Generic synchronous RAM: one write port and one read port with registered
// read data. Used for the heap storage; depends on nothing else.
module bmhq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/bounded_max_heap_queue_unit.sv
// Top level of the bounded max-heap queue: command interface, bound registers
// and the sequencer that walks the heap held in one bmhq_ram instance.
// Depends on bmhq_pkg and bmhq_ram.

// A priority queue of distinct signed values kept as a binary max-heap in a
// single RAM with registered read data. Raise start for one cycle while busy
// is low to request a push (op_i = 0) or a pop (op_i = 1); the result appears
// on done_o for exactly one cycle and cannot be stalled. A push first scans
// every stored entry for a duplicate, one RAM read per cycle, then sifts up,
// reading the parent and then comparing and writing at each level. A pop
// takes two reads to fetch the root and the last entry, then sifts down,
// reading the left child, then the right child, then comparing and writing
// at each level. A push out of range or a pop from an empty heap goes
// straight to the result; a duplicate or a full heap is only known after
// the scan. The single RAM read port forces these reads one at a time. The
// bound registers may be written whenever the block is idle.
module bounded_max_heap_queue_unit
  import bmhq_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic signed [DATA_WIDTH-1:0]  value_i,
  output logic                          done_o,
  output logic signed [DATA_WIDTH-1:0]  popped_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic signed [DATA_WIDTH-1:0]  top_value_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [REG_IDX_W-1:0]          cfg_index_i,
  input  logic [DATA_WIDTH-1:0]         cfg_data_i
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CHW  = AW + 2;
  localparam int SW   = 4;

  localparam logic [SW-1:0] S_IDLE   = 4'd0;
  localparam logic [SW-1:0] S_SCAN   = 4'd1;
  localparam logic [SW-1:0] S_UP_RD  = 4'd2;
  localparam logic [SW-1:0] S_UP_CMP = 4'd3;
  localparam logic [SW-1:0] S_POP_R1 = 4'd4;
  localparam logic [SW-1:0] S_POP_X  = 4'd5;
  localparam logic [SW-1:0] S_DN_RL  = 4'd6;
  localparam logic [SW-1:0] S_DN_RR  = 4'd7;
  localparam logic [SW-1:0] S_DN_CMP = 4'd8;
  localparam logic [SW-1:0] S_FIN    = 4'd9;
  localparam logic [SW-1:0] S_OUT    = 4'd10;

  logic [SW-1:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic          dup_q, dup_d;
  logic          done_q, done_d;

  logic signed [DATA_WIDTH-1:0] upper_q, lower_q;

  logic signed [DATA_WIDTH-1:0] x_q, x_d;
  logic signed [DATA_WIDTH-1:0] left_q, left_d;
  logic signed [DATA_WIDTH-1:0] popped_q, popped_d;
  logic [STATUS_W-1:0]          status_q, status_d;
  logic [AW-1:0]                pos_q, pos_d;

  logic signed [DATA_WIDTH-1:0] res_popped_q, res_popped_d;
  logic [STATUS_W-1:0]          res_status_q, res_status_d;
  logic signed [DATA_WIDTH-1:0] res_top_q, res_top_d;
  logic [CW-1:0]                res_count_q, res_count_d;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0]        wr_data, rd_data;
  logic signed [DATA_WIDTH-1:0] rd_val;

  logic [AW-1:0]  pos_m1, parent;
  logic [CHW-1:0] child_l, child_r, cnt_ext;
  logic           has_right, take_right;
  logic signed [DATA_WIDTH-1:0] big_val;
  logic [AW-1:0]  big_idx;
  logic           in_range;

  bmhq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign rd_val = $signed(rd_data);

  // Heap index arithmetic: parent of pos, and both children of pos.
  assign pos_m1     = pos_q - 1'b1;
  assign parent     = AW'(pos_m1 >> 1);
  assign child_l    = CHW'({pos_q, 1'b1});
  assign child_r    = child_l + 1'b1;
  assign cnt_ext    = CHW'(cnt_q);
  assign has_right  = child_r < cnt_ext;
  assign take_right = has_right && (rd_val > left_q);
  assign big_val    = take_right ? rd_val : left_q;
  assign big_idx    = take_right ? AW'(child_r) : AW'(child_l);
  assign in_range   = (value_i < upper_q) && (value_i > lower_q);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign popped_o    = res_popped_q;
  assign status_o    = res_status_q;
  assign top_value_o = res_top_q;
  assign count_o     = res_count_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    dup_d        = dup_q;
    done_d       = 1'b0;
    x_d          = x_q;
    left_d       = left_q;
    popped_d     = popped_q;
    status_d     = status_q;
    pos_d        = pos_q;
    res_popped_d = res_popped_q;
    res_status_d = res_status_q;
    res_top_d    = res_top_q;
    res_count_d  = res_count_q;
    wr_en        = 1'b0;
    wr_addr      = pos_q;
    wr_data      = x_q;
    rd_addr      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          x_d      = value_i;
          popped_d = '0;
          status_d = ST_OK;
          if (op_i == OP_PUSH) begin
            if (!in_range) begin
              status_d = ST_RANGE;
              state_d  = S_FIN;
            end else begin
              idx_d   = '0;
              pend_d  = 1'b0;
              dup_d   = 1'b0;
              state_d = S_SCAN;
            end
          end else if (cnt_q == '0) begin
            popped_d = lower_q;
            status_d = ST_EMPTY;
            state_d  = S_FIN;
          end else begin
            rd_addr = '0;
            state_d = S_POP_R1;
          end
        end
      end

      // One read issued per cycle; the data of the previous read is compared.
      S_SCAN: begin
        if (pend_q && (rd_val == x_q)) begin
          dup_d = 1'b1;
        end
        if (idx_q < cnt_q) begin
          rd_addr = AW'(idx_q);
          idx_d   = idx_q + 1'b1;
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (dup_q) begin
              status_d = ST_DUP;
              state_d  = S_FIN;
            end else if (cnt_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              pos_d   = AW'(cnt_q);
              cnt_d   = cnt_q + 1'b1;
              state_d = S_UP_RD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = S_FIN;
        end else begin
          rd_addr = parent;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (x_q > rd_val) begin
          wr_data = rd_data;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end

      S_POP_R1: begin
        popped_d = rd_val;
        rd_addr  = AW'(cnt_q - 1'b1);
        state_d  = S_POP_X;
      end

      // The last entry moves to the root; it is written only where it settles.
      S_POP_X: begin
        x_d   = rd_val;
        cnt_d = cnt_q - 1'b1;
        pos_d = '0;
        if (cnt_q == CW'(1)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DN_RL;
        end
      end

      S_DN_RL: begin
        if (child_l >= cnt_ext) begin
          wr_en   = 1'b1;
          state_d = S_FIN;
        end else begin
          rd_addr = AW'(child_l);
          state_d = S_DN_RR;
        end
      end

      S_DN_RR: begin
        left_d  = rd_val;
        rd_addr = AW'(child_r);
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        wr_en = 1'b1;
        if (big_val > x_q) begin
          wr_data = big_val;
          pos_d   = big_idx;
          state_d = S_DN_RL;
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        rd_addr = '0;
        state_d = S_OUT;
      end

      S_OUT: begin
        res_popped_d = popped_q;
        res_status_d = status_q;
        res_count_d  = cnt_q;
        res_top_d    = (cnt_q == '0) ? '1 : rd_val;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      dup_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      dup_q   <= dup_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= DATA_WIDTH'(UPPER_RESET);
      lower_q <= DATA_WIDTH'(LOWER_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_UPPER: upper_q <= $signed(cfg_data_i);
        REG_LOWER: lower_q <= $signed(cfg_data_i);
        default:   upper_q <= upper_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    left_q       <= left_d;
    popped_q     <= popped_d;
    status_q     <= status_d;
    pos_q        <= pos_d;
    res_popped_q <= res_popped_d;
    res_status_q <= res_status_d;
    res_top_q    <= res_top_d;
    res_count_q  <= res_count_d;
  end

endmodule

FILE: hw/rtl/bmhq_checker.sv
// Port-level checker for the bounded max-heap queue, bound to the top level.
// Depends on bmhq_pkg and bounded_max_heap_queue_unit.
module bmhq_checker
  import bmhq_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [STATUS_W-1:0]           status_o,
  input logic [DATA_WIDTH-1:0]         top_value_o,
  input logic [$clog2(CAPACITY+1)-1:0] count_o
);

  // Every accepted request raises busy in the following cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result is only presented once the block has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_o <= CAPACITY))
    else $error("count beyond capacity");

  // An empty heap reports all ones as its top.
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (count_o == '0)) |-> (top_value_o == {DATA_WIDTH{1'b1}}))
    else $error("empty heap with a top value");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY)) |-> (count_o == '0))
    else $error("empty status with stored entries");

endmodule

bind bounded_max_heap_queue_unit bmhq_checker #(
  .CAPACITY  (CAPACITY),
  .DATA_WIDTH(DATA_WIDTH)
) u_bmhq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .status_o   (status_o),
  .top_value_o(top_value_o),
  .count_o    (count_o)
);
